// ===== rtl/core/rrsw_pkg.sv =====
// shared types and constants for the round-robin scheduler with wakeup
// used by the channel interfaces and the top level; no dependencies
`timescale 1ns / 1ps

package rrsw_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;

  localparam int KIND_W  = 2;
  localparam int PID_W   = 16;
  localparam int TIME_W  = 16;
  localparam int ENTRY_W = PID_W + TIME_W;
  localparam int CNT_W   = 32;
  localparam int UTIL_W  = 7;
  localparam int PER_W   = 16;

  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_LOAD_READY   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD_BLOCKED = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TICK         = 2'd2;

  // register word index
  localparam logic [APB_AW-3:0] REG_WAKE_PERIOD = 1'b0;

  localparam logic [PER_W-1:0] WAKE_PERIOD_RST = 16'd4;
  localparam int               PCT_SCALE       = 100;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_WAKE,
    S_MUL,
    S_DIV,
    S_DONE
  } state_t;

  // per-item flags gathered while the item is worked on
  typedef struct packed {
    logic [PID_W-1:0] running_pid;
    logic             ran;
    logic             idle;
    logic             finished;
    logic             woke;
    logic [PID_W-1:0] woke_pid;
    logic             load_rejected;
  } flags_t;

  typedef struct packed {
    logic [PID_W-1:0]  running_pid;
    logic              ran;
    logic              idle;
    logic              finished;
    logic              woke;
    logic [PID_W-1:0]  woke_pid;
    logic              all_done;
    logic              load_rejected;
    logic [CNT_W-1:0]  busy_count;
    logic [CNT_W-1:0]  idle_count;
    logic [UTIL_W-1:0] utilization_percent;
  } res_t;

endpackage

// ===== rtl/core/rrsw_in_if.sv =====
// input channel of the scheduler: valid/ready plus one item
// depends on rrsw_pkg for field widths
`timescale 1ns / 1ps

interface rrsw_in_if;
  logic                       valid;
  logic                       ready;
  logic [rrsw_pkg::KIND_W-1:0] kind;
  logic [rrsw_pkg::PID_W-1:0]  process_id;
  logic [rrsw_pkg::TIME_W-1:0] service_time;

  modport source (output valid, output kind, output process_id, output service_time,
                  input ready);
  modport sink   (input valid, input kind, input process_id, input service_time,
                  output ready);
endinterface

// ===== rtl/core/rrsw_out_if.sv =====
// result channel of the scheduler: valid/ready plus one result
// depends on rrsw_pkg for field widths
`timescale 1ns / 1ps

interface rrsw_out_if;
  logic                        valid;
  logic                        ready;
  logic [rrsw_pkg::PID_W-1:0]  running_pid;
  logic                        ran;
  logic                        idle;
  logic                        finished;
  logic                        woke;
  logic [rrsw_pkg::PID_W-1:0]  woke_pid;
  logic                        all_done;
  logic                        load_rejected;
  logic [rrsw_pkg::CNT_W-1:0]  busy_count;
  logic [rrsw_pkg::CNT_W-1:0]  idle_count;
  logic [rrsw_pkg::UTIL_W-1:0] utilization_percent;

  modport source (output valid, output running_pid, output ran, output idle,
                  output finished, output woke, output woke_pid, output all_done,
                  output load_rejected, output busy_count, output idle_count,
                  output utilization_percent, input ready);
  modport sink   (input valid, input running_pid, input ran, input idle,
                  input finished, input woke, input woke_pid, input all_done,
                  input load_rejected, input busy_count, input idle_count,
                  input utilization_percent, output ready);
endinterface

// ===== rtl/core/round_robin_scheduler_with_wakeup.sv =====
// Round-robin scheduler with a one-slice quantum and periodic wakeup of blocked
// processes. Both queues sit in synchronous memories (one write and one registered
// read per cycle). A load, an unused kind or a tick that finds both queues empty
// goes from S_IDLE straight to S_DONE. A working tick passes S_EXEC, S_WAKE only
// when a blocked process wakes (the second write into the ready memory), S_MUL,
// the seven-step restoring division in S_DIV that produces the utilization
// percentage, and S_DONE. The next item is taken while a result still waits in
// the output register. No clearing pass after reset.
// depends on rrsw_pkg, rrsw_in_if, rrsw_out_if
`timescale 1ns / 1ps

module round_robin_scheduler_with_wakeup #(
  parameter int QUEUE_DEPTH = rrsw_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  rrsw_in_if.sink                     sched_in,
  rrsw_out_if.source                  sched_out,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rrsw_pkg::APB_AW-1:0] paddr,
  input  logic [rrsw_pkg::APB_DW-1:0] pwdata,
  output logic [rrsw_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);

  localparam int AW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FW   = $clog2(QUEUE_DEPTH + 1);
  localparam int NUMW = rrsw_pkg::CNT_W + rrsw_pkg::UTIL_W + 1;
  localparam int DENW = rrsw_pkg::CNT_W + 1;
  localparam int QBW  = $clog2(rrsw_pkg::UTIL_W);

  localparam logic [AW:0]        DEPTH_A = (AW+1)'(QUEUE_DEPTH);
  localparam logic [FW-1:0]      DEPTH_F = FW'(QUEUE_DEPTH);
  localparam logic [QBW-1:0]     QB_TOP  = QBW'(rrsw_pkg::UTIL_W - 1);
  localparam logic [NUMW-1:0]    SCALE   = NUMW'(rrsw_pkg::PCT_SCALE);
  localparam logic [rrsw_pkg::CNT_W-1:0] CNT_MAX = '1;

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a,
                                             input logic [AW-1:0] b);
    logic [AW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= DEPTH_A) begin
      s = s - DEPTH_A;
    end
    return s[AW-1:0];
  endfunction

  // ---------------------------------------------------------------- state
  rrsw_pkg::state_t state, state_next;

  logic [rrsw_pkg::PER_W-1:0] wake_period;
  logic [AW-1:0]              ready_front, blocked_front;
  logic [FW-1:0]              ready_fill, blocked_fill;
  logic [rrsw_pkg::PER_W-1:0] wake_counter;
  logic [rrsw_pkg::CNT_W-1:0] busy_total, idle_total;
  logic [rrsw_pkg::UTIL_W-1:0] util;

  rrsw_pkg::flags_t pend;
  rrsw_pkg::res_t   out_res;
  logic             out_valid;

  logic [rrsw_pkg::ENTRY_W-1:0] wake_entry;
  logic [AW-1:0]                wake_slot;

  logic [NUMW-1:0]             num;
  logic [DENW-1:0]             den;
  logic [rrsw_pkg::UTIL_W-1:0] quot;
  logic [QBW-1:0]              qbit;

  // queue memories
  logic [rrsw_pkg::ENTRY_W-1:0] ready_mem   [QUEUE_DEPTH];
  logic [rrsw_pkg::ENTRY_W-1:0] blocked_mem [QUEUE_DEPTH];
  logic [rrsw_pkg::ENTRY_W-1:0] ready_rdata, blocked_rdata;

  logic                         ready_we, blocked_we;
  logic [AW-1:0]                ready_waddr, blocked_waddr;
  logic [rrsw_pkg::ENTRY_W-1:0] ready_wdata, blocked_wdata;

  // ---------------------------------------------------------------- input decode
  logic                        in_ready, accept, out_free;
  logic [rrsw_pkg::TIME_W-1:0] svc_eff;
  logic [rrsw_pkg::ENTRY_W-1:0] load_entry;
  logic                        ready_room, blocked_room;
  logic                        load_rej;

  assign accept     = sched_in.valid && in_ready;
  assign out_free   = !out_valid || sched_out.ready;
  assign svc_eff    = (sched_in.service_time == '0) ? rrsw_pkg::TIME_W'(1)
                                                    : sched_in.service_time;
  assign load_entry = {sched_in.process_id, svc_eff};
  assign ready_room   = ready_fill < DEPTH_F;
  assign blocked_room = blocked_fill < DEPTH_F;
  assign load_rej     = (sched_in.kind == rrsw_pkg::KIND_LOAD_READY && !ready_room) ||
                        (sched_in.kind == rrsw_pkg::KIND_LOAD_BLOCKED && !blocked_room);

  // ---------------------------------------------------------------- tick datapath
  // valid in S_EXEC: read data reflects the heads, which did not move since accept
  logic                        run, rotate, due, wake;
  logic [rrsw_pkg::TIME_W-1:0] rem;
  logic [FW-1:0]               fill1;
  logic [AW-1:0]               head1, rot_slot;
  logic [rrsw_pkg::PER_W:0]    next_cnt;

  always_comb begin
    run      = ready_fill != '0;
    rem      = ready_rdata[rrsw_pkg::TIME_W-1:0] - rrsw_pkg::TIME_W'(1);
    rotate   = run && (rem != '0);
    fill1    = ready_fill - FW'(run) + FW'(rotate);
    head1    = run ? wrap_add(ready_front, AW'(1)) : ready_front;
    rot_slot = wrap_add(ready_front, ready_fill[AW-1:0]);
    next_cnt = {1'b0, wake_counter} + (rrsw_pkg::PER_W+1)'(1);
    due      = next_cnt >= {1'b0, wake_period};
    wake     = due && (blocked_fill != '0) && (fill1 < DEPTH_F);
  end

  // division step
  logic [NUMW-1:0] den_sh;
  logic            ge;
  always_comb begin
    den_sh = NUMW'(den) << qbit;
    ge     = num >= den_sh;
  end

  // ---------------------------------------------------------------- fsm
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rrsw_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      rrsw_pkg::S_IDLE: begin
        if (accept) begin
          if (sched_in.kind == rrsw_pkg::KIND_TICK &&
              (ready_fill != '0 || blocked_fill != '0)) begin
            state_next = rrsw_pkg::S_EXEC;
          end else begin
            state_next = rrsw_pkg::S_DONE;
          end
        end
      end
      rrsw_pkg::S_EXEC: state_next = wake ? rrsw_pkg::S_WAKE : rrsw_pkg::S_MUL;
      rrsw_pkg::S_WAKE: state_next = rrsw_pkg::S_MUL;
      rrsw_pkg::S_MUL:  state_next = rrsw_pkg::S_DIV;
      rrsw_pkg::S_DIV: begin
        if (qbit == '0) begin
          state_next = rrsw_pkg::S_DONE;
        end
      end
      rrsw_pkg::S_DONE: begin
        if (out_free) begin
          state_next = rrsw_pkg::S_IDLE;
        end
      end
      default: state_next = rrsw_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    ready_we      = 1'b0;
    ready_waddr   = rot_slot;
    ready_wdata   = {ready_rdata[rrsw_pkg::ENTRY_W-1:rrsw_pkg::TIME_W], rem};
    blocked_we    = 1'b0;
    blocked_waddr = wrap_add(blocked_front, blocked_fill[AW-1:0]);
    blocked_wdata = load_entry;
    unique case (state)
      rrsw_pkg::S_IDLE: begin
        in_ready    = 1'b1;
        ready_waddr = wrap_add(ready_front, ready_fill[AW-1:0]);
        ready_wdata = load_entry;
        ready_we    = accept && sched_in.kind == rrsw_pkg::KIND_LOAD_READY && ready_room;
        blocked_we  = accept && sched_in.kind == rrsw_pkg::KIND_LOAD_BLOCKED &&
                      blocked_room;
      end
      rrsw_pkg::S_EXEC: ready_we = rotate;
      rrsw_pkg::S_WAKE: begin
        ready_we    = 1'b1;
        ready_waddr = wake_slot;
        ready_wdata = wake_entry;
      end
      rrsw_pkg::S_MUL, rrsw_pkg::S_DIV, rrsw_pkg::S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  assign sched_in.ready = in_ready;

  // ---------------------------------------------------------------- memories
  always_ff @(posedge clk) begin
    if (ready_we) begin
      ready_mem[ready_waddr] <= ready_wdata;
    end
    ready_rdata <= ready_mem[ready_front];
  end

  always_ff @(posedge clk) begin
    if (blocked_we) begin
      blocked_mem[blocked_waddr] <= blocked_wdata;
    end
    blocked_rdata <= blocked_mem[blocked_front];
  end

  // ---------------------------------------------------------------- control state
  always_ff @(posedge clk) begin
    if (rst) begin
      ready_front   <= '0;
      ready_fill    <= '0;
      blocked_front <= '0;
      blocked_fill  <= '0;
      wake_counter  <= '0;
      busy_total    <= '0;
      idle_total    <= '0;
      util          <= '0;
    end else begin
      unique case (state)
        rrsw_pkg::S_IDLE: begin
          if (ready_we) begin
            ready_fill <= ready_fill + FW'(1);
          end
          if (blocked_we) begin
            blocked_fill <= blocked_fill + FW'(1);
          end
        end
        rrsw_pkg::S_EXEC: begin
          ready_front <= head1;
          ready_fill  <= fill1 + FW'(wake);
          if (wake) begin
            blocked_front <= wrap_add(blocked_front, AW'(1));
            blocked_fill  <= blocked_fill - FW'(1);
            wake_counter  <= '0;
          end else if (due) begin
            wake_counter <= wake_period;
          end else begin
            wake_counter <= next_cnt[rrsw_pkg::PER_W-1:0];
          end
          if (run) begin
            if (busy_total != CNT_MAX) begin
              busy_total <= busy_total + rrsw_pkg::CNT_W'(1);
            end
          end else if (idle_total != CNT_MAX) begin
            idle_total <= idle_total + rrsw_pkg::CNT_W'(1);
          end
        end
        rrsw_pkg::S_DIV: begin
          if (qbit == '0) begin
            util <= (den == '0) ? '0 : (quot | rrsw_pkg::UTIL_W'(ge));
          end
        end
        rrsw_pkg::S_WAKE, rrsw_pkg::S_MUL, rrsw_pkg::S_DONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------- payload
  always_ff @(posedge clk) begin
    unique case (state)
      rrsw_pkg::S_IDLE: begin
        if (accept) begin
          pend <= '{running_pid: '0, ran: 1'b0, idle: 1'b0, finished: 1'b0,
                    woke: 1'b0, woke_pid: '0, load_rejected: load_rej};
        end
      end
      rrsw_pkg::S_EXEC: begin
        pend.running_pid <= run ? ready_rdata[rrsw_pkg::ENTRY_W-1:rrsw_pkg::TIME_W] : '0;
        pend.ran         <= run;
        pend.idle        <= !run;
        pend.finished    <= run && !rotate;
        pend.woke        <= wake;
        pend.woke_pid    <= wake ? blocked_rdata[rrsw_pkg::ENTRY_W-1:rrsw_pkg::TIME_W]
                                 : '0;
        wake_entry       <= blocked_rdata;
        wake_slot        <= wrap_add(head1, fill1[AW-1:0]);
      end
      rrsw_pkg::S_MUL: begin
        // busy*100 over busy+idle, quotient never above 100
        num  <= NUMW'(busy_total) * SCALE;
        den  <= DENW'(busy_total) + DENW'(idle_total);
        quot <= '0;
        qbit <= QB_TOP;
      end
      rrsw_pkg::S_DIV: begin
        if (ge) begin
          num        <= num - den_sh;
          quot[qbit] <= 1'b1;
        end
        qbit <= qbit - QBW'(1);
      end
      rrsw_pkg::S_WAKE, rrsw_pkg::S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------- result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == rrsw_pkg::S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (sched_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == rrsw_pkg::S_DONE && out_free) begin
      out_res.running_pid         <= pend.running_pid;
      out_res.ran                 <= pend.ran;
      out_res.idle                <= pend.idle;
      out_res.finished            <= pend.finished;
      out_res.woke                <= pend.woke;
      out_res.woke_pid            <= pend.woke_pid;
      out_res.all_done            <= (ready_fill == '0) && (blocked_fill == '0);
      out_res.load_rejected       <= pend.load_rejected;
      out_res.busy_count          <= busy_total;
      out_res.idle_count          <= idle_total;
      out_res.utilization_percent <= util;
    end
  end

  assign sched_out.valid               = out_valid;
  assign sched_out.running_pid         = out_res.running_pid;
  assign sched_out.ran                 = out_res.ran;
  assign sched_out.idle                = out_res.idle;
  assign sched_out.finished            = out_res.finished;
  assign sched_out.woke                = out_res.woke;
  assign sched_out.woke_pid            = out_res.woke_pid;
  assign sched_out.all_done            = out_res.all_done;
  assign sched_out.load_rejected       = out_res.load_rejected;
  assign sched_out.busy_count          = out_res.busy_count;
  assign sched_out.idle_count          = out_res.idle_count;
  assign sched_out.utilization_percent = out_res.utilization_percent;

  // ---------------------------------------------------------------- register port
  logic cfg_hit;
  assign cfg_hit = paddr[rrsw_pkg::APB_AW-1:2] == rrsw_pkg::REG_WAKE_PERIOD;

  always_ff @(posedge clk) begin
    if (rst) begin
      wake_period <= rrsw_pkg::WAKE_PERIOD_RST;
    end else if (psel && penable && pwrite && pready && cfg_hit) begin
      wake_period <= pwdata[rrsw_pkg::PER_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = cfg_hit ? rrsw_pkg::APB_DW'(wake_period) : '0;

endmodule
